[src/lmpo_pkg.sv]
package lmpo_pkg;

    // Field widths of the streams
    localparam int LUMA_W  = 8;
    localparam int COORD_W = 12;

    // Frame size limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int DIM_W      = 13;

    // APB register map
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_TS_PAYLOAD  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SEQ_PAYLOAD = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_W     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_H     = 2'd3;

    localparam logic [DIM_W-1:0] FRAME_W_RESET = 13'd1920;
    localparam logic [DIM_W-1:0] FRAME_H_RESET = 13'd1080;
    localparam logic [DIM_W-1:0] MIN_W         = 13'd240;
    localparam logic [DIM_W-1:0] MIN_H         = 13'd120;

    // Marker geometry
    localparam logic [COORD_W-1:0] ROW_TS_TOP  = 12'd20;
    localparam logic [COORD_W-1:0] ROW_SEQ_TOP = 12'd62;
    localparam logic [COORD_W-1:0] ROW_LINES   = 12'd21;
    localparam logic [COORD_W-1:0] BOX_START   = 12'd20;
    localparam logic [COORD_W-1:0] BOX_PITCH   = 12'd29;
    localparam logic [COORD_W-1:0] BOX_SPAN    = 12'd26;
    localparam int BOX_COUNT = 40;
    localparam int BIT_IDX_W = 6;

    // Division by the box pitch: q = (d * RECIP_MUL) >> RECIP_SHIFT, exact for any 12-bit d
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 15'd18079;
    localparam int QUOT_W = 8;

    localparam logic [LUMA_W-1:0] LUMA_ONE  = 8'd235;
    localparam logic [LUMA_W-1:0] LUMA_ZERO = 8'd16;

    localparam logic [7:0] CRC_POLY = 8'h07;

    typedef struct packed {
        logic [31:0]      ts_payload;
        logic [31:0]      seq_payload;
        logic [7:0]       ts_crc;
        logic [7:0]       seq_crc;
        logic [DIM_W-1:0] width_eff;
        logic [DIM_W-1:0] height_eff;
        logic             draw_en;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic                 row_seq;
        logic [BIT_IDX_W-1:0] bit_idx;
    } geom_t;

    // CRC-8, init 0, MSB first over the whole word; flattens to an XOR network
    function automatic logic [7:0] crc8_32(input logic [31:0] v);
        logic [7:0] c;
        logic       fb;
        c = 8'h00;
        for (int i = 31; i >= 0; i--) begin
            fb = c[7] ^ v[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

[src/latency_marker_pixel_overlay_core.sv]
// Channel  | Dir | Handshake        | Contents
// s_       | in  | s_tvalid/tready  | pixel word: luma_in, pixel_x, pixel_y
// m_       | out | m_tvalid/tready  | result word: luma_out, in_marker flag
// APB      | in  | psel/penable     | payloads, frame width, frame height
//
// One word per cycle while m_tready is high; each word is registered in both stages.
// Path: input register -> box decode and bit select -> output register.
// aresetn is synchronous, active low; it empties both stages and restores the registers.
// s_tready stays high while either stage is free, so input keeps flowing while a
// result waits on m_tready; it drops only when both stages are full and m_ stalls.
module latency_marker_pixel_overlay_core
    import lmpo_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // luma_in[7:0], pixel_x[19:8], pixel_y[31:20]

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // luma_out[7:0]
    output logic              m_tuser    // in_marker[0]
);

    cfg_t  cfg;
    geom_t geom;

    logic               in_v_reg;
    logic [LUMA_W-1:0]  in_luma_reg;
    logic [COORD_W-1:0] in_x_reg;
    logic [COORD_W-1:0] in_y_reg;

    logic               out_v_reg;
    logic [LUMA_W-1:0]  out_luma_reg;
    logic               out_mark_reg;
    logic [LUMA_W-1:0]  luma_next;

    logic               out_ready;
    logic [39:0]        row_bits;
    logic               bit_val;

    lmpo_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmpo_geom u_geom (
        .cfg     (cfg),
        .pixel_x (in_x_reg),
        .pixel_y (in_y_reg),
        .geom    (geom)
    );

    assign out_ready = !out_v_reg || m_tready;
    assign s_tready  = !in_v_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_tready) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_luma_reg <= s_tdata[7:0];
            in_x_reg    <= s_tdata[19:8];
            in_y_reg    <= s_tdata[31:20];
        end
    end

    assign row_bits  = geom.row_seq ? {cfg.seq_payload, cfg.seq_crc}
                                    : {cfg.ts_payload, cfg.ts_crc};
    assign bit_val   = row_bits[geom.bit_idx];
    assign luma_next = !geom.hit ? in_luma_reg : (bit_val ? LUMA_ONE : LUMA_ZERO);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_ready) begin
            out_v_reg <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && in_v_reg) begin
            out_luma_reg <= luma_next;
            out_mark_reg <= geom.hit;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_luma_reg;
    assign m_tuser  = out_mark_reg;

    // A marked pixel carries one of the two box levels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == LUMA_ONE || m_tdata == LUMA_ZERO))
        else $error("marked pixel with a level other than the box levels");

    // An unmarked pixel passes its luma through unchanged
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_ready && in_v_reg && !geom.hit |=> m_tdata == $past(in_luma_reg) && !m_tuser)
        else $error("pass-through pixel altered");

    // Input stalls only when both stages hold a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_v_reg && out_v_reg && !m_tready)
        else $error("input stalled with a free stage");

    // Boxes are drawn only on the marker lines of a large enough frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_v_reg && geom.hit |-> cfg.draw_en
            && ((in_y_reg >= ROW_TS_TOP && in_y_reg < ROW_TS_TOP + ROW_LINES)
             || (in_y_reg >= ROW_SEQ_TOP && in_y_reg < ROW_SEQ_TOP + ROW_LINES)))
        else $error("marker drawn outside the marker rows");

    // Reset empties the output stage
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

[src/lmpo_regs.sv]
module lmpo_regs
    import lmpo_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [31:0]      ts_payload_reg;
    logic [31:0]      seq_payload_reg;
    logic [7:0]       ts_crc_reg;
    logic [7:0]       seq_crc_reg;
    logic [DIM_W-1:0] frame_w_reg;
    logic [DIM_W-1:0] frame_h_reg;
    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic [REG_IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_payload_reg  <= '0;
            seq_payload_reg <= '0;
            ts_crc_reg      <= crc8_32(32'h0);
            seq_crc_reg     <= crc8_32(32'h0);
            frame_w_reg     <= FRAME_W_RESET;
            frame_h_reg     <= FRAME_H_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_TS_PAYLOAD: begin
                    ts_payload_reg <= pwdata;
                    ts_crc_reg     <= crc8_32(pwdata);
                end
                REG_SEQ_PAYLOAD: begin
                    seq_payload_reg <= pwdata;
                    seq_crc_reg     <= crc8_32(pwdata);
                end
                REG_FRAME_W: frame_w_reg <= pwdata[DIM_W-1:0];
                REG_FRAME_H: frame_h_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TS_PAYLOAD:  prdata = ts_payload_reg;
            REG_SEQ_PAYLOAD: prdata = seq_payload_reg;
            REG_FRAME_W:     prdata = DATA_W'(frame_w_reg);
            REG_FRAME_H:     prdata = DATA_W'(frame_h_reg);
            default:         prdata = '0;
        endcase
    end

    // Saturate oversized frame registers
    assign width_eff  = (frame_w_reg > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : frame_w_reg;
    assign height_eff = (frame_h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_h_reg;

    assign cfg.ts_payload  = ts_payload_reg;
    assign cfg.seq_payload = seq_payload_reg;
    assign cfg.ts_crc      = ts_crc_reg;
    assign cfg.seq_crc     = seq_crc_reg;
    assign cfg.width_eff   = width_eff;
    assign cfg.height_eff  = height_eff;
    assign cfg.draw_en     = (width_eff >= MIN_W) && (height_eff >= MIN_H);

endmodule

[src/lmpo_geom.sv]
module lmpo_geom
    import lmpo_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [COORD_W-1:0] pixel_x,
    input  logic [COORD_W-1:0] pixel_y,
    output geom_t              geom
);

    logic                       in_frame;
    logic                       in_ts_row;
    logic                       in_seq_row;
    logic [COORD_W-1:0]         d;
    logic [COORD_W+RECIP_W-1:0] prod;
    logic [QUOT_W-1:0]          box;
    logic [COORD_W-1:0]         off;

    assign in_frame = cfg.draw_en
                   && ({1'b0, pixel_x} < cfg.width_eff)
                   && ({1'b0, pixel_y} < cfg.height_eff)
                   && (pixel_x >= BOX_START);

    assign in_ts_row  = (pixel_y >= ROW_TS_TOP)  && (pixel_y < ROW_TS_TOP + ROW_LINES);
    assign in_seq_row = (pixel_y >= ROW_SEQ_TOP) && (pixel_y < ROW_SEQ_TOP + ROW_LINES);

    // Box number and offset within the pitch, by reciprocal multiply
    assign d    = pixel_x - BOX_START;
    assign prod = (COORD_W+RECIP_W)'(d) * (COORD_W+RECIP_W)'(RECIP_MUL);
    assign box  = prod[COORD_W+RECIP_W-1:RECIP_SHIFT];
    assign off  = d - COORD_W'(COORD_W'(box) * BOX_PITCH);

    assign geom.hit     = in_frame && (in_ts_row || in_seq_row)
                       && (box < QUOT_W'(BOX_COUNT)) && (off < BOX_SPAN);
    assign geom.row_seq = !in_ts_row;
    // Box 0 shows the top bit of the 40-bit word
    assign geom.bit_idx = BIT_IDX_W'(BOX_COUNT - 1) - box[BIT_IDX_W-1:0];

endmodule
